// ===== src/ryuy_pkg.sv =====
// Shared types, constants and helper functions for the RGB565 pair to YUY2 converter.
// Depends on nothing; every module of the block imports it.
package ryuy_pkg;

    // Fixed-point coefficients (scaled by 2^16, truncated)
    localparam int unsigned FRAC_BITS = 16;
    localparam logic [15:0] COEF_YR = 16'd19595;
    localparam logic [15:0] COEF_YG = 16'd38469;
    localparam logic [15:0] COEF_YB = 16'd7471;
    localparam logic [15:0] COEF_UR = 16'd11075;
    localparam logic [15:0] COEF_UG = 16'd21692;
    localparam logic [15:0] COEF_UB = 16'd32768;
    localparam logic [15:0] COEF_VR = 16'd32768;
    localparam logic [15:0] COEF_VG = 16'd27459;
    localparam logic [15:0] COEF_VB = 16'd5308;

    // Offsets folded into the 25-bit accumulators
    localparam logic [24:0] LUMA_BIAS   = 25'(16)  << FRAC_BITS;
    localparam logic [24:0] CHROMA_BIAS = 25'(128) << FRAC_BITS;

    // Output ranges
    localparam logic [8:0] LUMA_MIN   = 9'd16;
    localparam logic [8:0] LUMA_MAX   = 9'd235;
    localparam logic [8:0] CHROMA_MIN = 9'd16;
    localparam logic [8:0] CHROMA_MAX = 9'd240;

    // Both-black word bytes
    localparam logic [7:0] BLACK_LUMA   = 8'h00;
    localparam logic [7:0] BLACK_CHROMA = 8'h80;

    // Field-wise floor average masks for RGB565
    localparam logic [15:0] AVG_MASK_HALF = 16'hFBEF;
    localparam logic [15:0] AVG_MASK_LSB  = 16'h0821;

    // Channel index into product arrays
    localparam int unsigned CH_R = 0;
    localparam int unsigned CH_G = 1;
    localparam int unsigned CH_B = 2;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    // Stage 1: widened pixels and the widened pair average
    typedef struct packed {
        rgb_t px_first;
        rgb_t px_second;
        rgb_t px_avg;
        logic black;
    } widen_t;

    // Stage 2: coefficient products, indexed by channel
    typedef struct packed {
        logic [2:0][23:0] y_first;
        logic [2:0][23:0] y_second;
        logic [2:0][23:0] cb;
        logic [2:0][23:0] cr;
        logic             black;
    } prod_t;

    // Stage 3: shifted sums, not yet clamped
    typedef struct packed {
        logic [8:0] y_first;
        logic [8:0] y_second;
        logic [7:0] cb;
        logic [7:0] cr;
        logic       black;
    } sum_t;

    // Widen 5/6/5 fields to 8 bits by top-bit replication
    function automatic rgb_t widen565(input logic [15:0] p);
        rgb_t c;
        c.r = {p[15:11], p[15:13]};
        c.g = {p[10:5], p[10:9]};
        c.b = {p[4:0], p[4:2]};
        return c;
    endfunction

    // Constant coefficient times an 8-bit channel
    function automatic logic [23:0] mul_coef(input logic [15:0] c, input logic [7:0] v);
        return 24'(c) * 24'(v);
    endfunction

    function automatic logic [7:0] clamp9(input logic [8:0] v, input logic [8:0] lo,
                                          input logic [8:0] hi);
        logic [8:0] t;
        t = v;
        if (v < lo)
        begin
            t = lo;
        end
        else if (v > hi)
        begin
            t = hi;
        end
        return t[7:0];
    endfunction

endpackage

// ===== src/rgb565_pair_to_yuy2.sv =====
// Four stages (widen/average, multiply, sum, clamp/pack) each hold one transaction and
// advance independently under stall. Throughput: one pixel pair per cycle while the
// output is not stalled.
// Reset: rst_n asynchronously clears all stage valid bits; data registers are not reset.
// Depends on ryuy_pkg, ryuy_widen_avg, ryuy_mult, ryuy_sum, ryuy_clamp_pack.
module rgb565_pair_to_yuy2
    import ryuy_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // [15:0] pixel_first, [31:16] pixel_second
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata   // [7:0] luma_first, [15:8] chroma_blue,
                                       // [23:16] luma_second, [31:24] chroma_red
);

    logic   s1_valid;
    logic   s1_ready;
    widen_t s1_data;
    logic   s2_valid;
    logic   s2_ready;
    prod_t  s2_data;
    logic   s3_valid;
    logic   s3_ready;
    sum_t   s3_data;

    ryuy_widen_avg u_widen_avg (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .pixel_first  (s_axis_tdata[15:0]),
        .pixel_second (s_axis_tdata[31:16]),
        .out_valid    (s1_valid),
        .out_ready    (s1_ready),
        .out_data     (s1_data)
    );

    ryuy_mult u_mult (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (s1_data),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_data  (s2_data)
    );

    ryuy_sum u_sum (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .in_data   (s2_data),
        .out_valid (s3_valid),
        .out_ready (s3_ready),
        .out_data  (s3_data)
    );

    ryuy_clamp_pack u_clamp_pack (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s3_valid),
        .in_ready      (s3_ready),
        .in_data       (s3_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// ===== src/ryuy_widen_avg.sv =====
// Pipeline stage 1: widens both RGB565 pixels, forms their field-wise floor average
// and flags the both-black case. Depends on ryuy_pkg.
module ryuy_widen_avg
    import ryuy_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] pixel_first,
    input  logic [15:0] pixel_second,
    output logic        out_valid,
    input  logic        out_ready,
    output widen_t      out_data
);

    logic   valid_reg;
    widen_t data_reg;
    widen_t data_next;
    logic [15:0] avg_next;

    // Stage advances when empty or when downstream takes its contents
    assign in_ready = !valid_reg || out_ready;

    // Field-wise floor average; fields never carry into each other
    always_comb
    begin
        avg_next = ((pixel_first >> 1) & AVG_MASK_HALF)
                 + ((pixel_second >> 1) & AVG_MASK_HALF)
                 + (pixel_first & pixel_second & AVG_MASK_LSB);
        data_next.px_first  = widen565(pixel_first);
        data_next.px_second = widen565(pixel_second);
        data_next.px_avg    = widen565(avg_next);
        data_next.black     = ((pixel_first | pixel_second) == 16'h0000);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== src/ryuy_mult.sv =====
// Pipeline stage 2: the twelve constant-coefficient products for Y, Cb and Cr.
// Depends on ryuy_pkg.
module ryuy_mult
    import ryuy_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  widen_t in_data,
    output logic   out_valid,
    input  logic   out_ready,
    output prod_t  out_data
);

    logic  valid_reg;
    prod_t data_reg;
    prod_t data_next;

    assign in_ready = !valid_reg || out_ready;

    // Products; signs are applied in the sum stage
    always_comb
    begin
        data_next.y_first[CH_R]  = mul_coef(COEF_YR, in_data.px_first.r);
        data_next.y_first[CH_G]  = mul_coef(COEF_YG, in_data.px_first.g);
        data_next.y_first[CH_B]  = mul_coef(COEF_YB, in_data.px_first.b);
        data_next.y_second[CH_R] = mul_coef(COEF_YR, in_data.px_second.r);
        data_next.y_second[CH_G] = mul_coef(COEF_YG, in_data.px_second.g);
        data_next.y_second[CH_B] = mul_coef(COEF_YB, in_data.px_second.b);
        data_next.cb[CH_R]       = mul_coef(COEF_UR, in_data.px_avg.r);
        data_next.cb[CH_G]       = mul_coef(COEF_UG, in_data.px_avg.g);
        data_next.cb[CH_B]       = mul_coef(COEF_UB, in_data.px_avg.b);
        data_next.cr[CH_R]       = mul_coef(COEF_VR, in_data.px_avg.r);
        data_next.cr[CH_G]       = mul_coef(COEF_VG, in_data.px_avg.g);
        data_next.cr[CH_B]       = mul_coef(COEF_VB, in_data.px_avg.b);
        data_next.black          = in_data.black;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== src/ryuy_sum.sv =====
// Pipeline stage 3: adds products and offsets, keeps the integer part of each sum.
// Depends on ryuy_pkg.
module ryuy_sum
    import ryuy_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  prod_t in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output sum_t  out_data
);

    logic  valid_reg;
    sum_t  data_reg;
    sum_t  data_next;
    logic [24:0] acc_y_first;
    logic [24:0] acc_y_second;
    logic [24:0] acc_cb;
    logic [24:0] acc_cr;

    assign in_ready = !valid_reg || out_ready;

    // Chroma sums stay within 0..2^24, so modulo 2^25 arithmetic is exact
    always_comb
    begin
        acc_y_first  = LUMA_BIAS + 25'(in_data.y_first[CH_R])
                     + 25'(in_data.y_first[CH_G]) + 25'(in_data.y_first[CH_B]);
        acc_y_second = LUMA_BIAS + 25'(in_data.y_second[CH_R])
                     + 25'(in_data.y_second[CH_G]) + 25'(in_data.y_second[CH_B]);
        acc_cb       = CHROMA_BIAS + 25'(in_data.cb[CH_B])
                     - 25'(in_data.cb[CH_R]) - 25'(in_data.cb[CH_G]);
        acc_cr       = CHROMA_BIAS + 25'(in_data.cr[CH_R])
                     - 25'(in_data.cr[CH_G]) - 25'(in_data.cr[CH_B]);
        data_next.y_first  = acc_y_first[24:16];
        data_next.y_second = acc_y_second[24:16];
        data_next.cb       = acc_cb[23:16];
        data_next.cr       = acc_cr[23:16];
        data_next.black    = in_data.black;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== src/ryuy_clamp_pack.sv =====
// Pipeline stage 4 and output register: clamps Y, Cb, Cr, applies the both-black word
// and packs the YUY2 transaction. Depends on ryuy_pkg.
module ryuy_clamp_pack
    import ryuy_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  sum_t        in_data,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata
);

    logic        valid_reg;
    logic [31:0] data_reg;
    logic [31:0] data_next;
    logic [7:0]  y_first;
    logic [7:0]  y_second;
    logic [7:0]  cb;
    logic [7:0]  cr;

    assign in_ready = !valid_reg || m_axis_tready;

    // Clamp, then override with the fixed word when both pixels are black
    always_comb
    begin
        y_first  = clamp9(in_data.y_first, LUMA_MIN, LUMA_MAX);
        y_second = clamp9(in_data.y_second, LUMA_MIN, LUMA_MAX);
        cb       = clamp9({1'b0, in_data.cb}, CHROMA_MIN, CHROMA_MAX);
        cr       = clamp9({1'b0, in_data.cr}, CHROMA_MIN, CHROMA_MAX);
        if (in_data.black)
        begin
            y_first  = BLACK_LUMA;
            y_second = BLACK_LUMA;
            cb       = BLACK_CHROMA;
            cr       = BLACK_CHROMA;
        end
        data_next = {cr, y_second, cb, y_first};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;

    // Luma is zero for both samples or for neither
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((m_axis_tdata[7:0] == 8'h00) == (m_axis_tdata[23:16] == 8'h00)))
        else $error("luma bytes disagree on the black case");

    // Zero luma only comes with neutral chroma
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tdata[7:0] == 8'h00))
        |-> ((m_axis_tdata[15:8] == BLACK_CHROMA) && (m_axis_tdata[31:24] == BLACK_CHROMA)))
        else $error("black word has wrong chroma");

    // Non-black transactions stay inside the nominal ranges
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tdata[7:0] != 8'h00))
        |-> ((m_axis_tdata[7:0] >= 8'd16) && (m_axis_tdata[7:0] <= 8'd235)
          && (m_axis_tdata[23:16] >= 8'd16) && (m_axis_tdata[23:16] <= 8'd235)
          && (m_axis_tdata[15:8] >= 8'd16) && (m_axis_tdata[15:8] <= 8'd240)
          && (m_axis_tdata[31:24] >= 8'd16) && (m_axis_tdata[31:24] <= 8'd240)))
        else $error("output byte out of range");

    // A held transaction does not change
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("stalled output changed");

endmodule
